// ===== design/vse_pkg.sv =====
// ----------------------------------------------------------------------------
// vse_pkg
// shared constants, types and helpers of the vector slide element unit
// ----------------------------------------------------------------------------
package vse_pkg;

	localparam int MAX_LENGTH = 64;
	localparam int POS_W      = $clog2(MAX_LENGTH);
	localparam int LEN_W      = $clog2(MAX_LENGTH + 1);

	localparam int ELEM_W   = 64;
	localparam int CNT_W    = 7;
	localparam int IDX_W    = 3;

	// slide modes
	localparam logic [1:0] MODE_SLIDEUP    = 2'd0;
	localparam logic [1:0] MODE_SLIDE1UP   = 2'd1;
	localparam logic [1:0] MODE_SLIDEDOWN  = 2'd2;
	localparam logic [1:0] MODE_SLIDE1DOWN = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET = 3'd1;
	localparam logic [IDX_W-1:0] REG_SCALAR = 3'd2;
	localparam logic [IDX_W-1:0] REG_LENGTH = 3'd3;
	localparam logic [IDX_W-1:0] REG_MASKED = 3'd4;
	localparam logic [IDX_W-1:0] REG_EWIDTH = 3'd5;

	// result source select
	localparam logic [2:0] SEL_OLD    = 3'd0;
	localparam logic [2:0] SEL_SRC    = 3'd1;
	localparam logic [2:0] SEL_BUF    = 3'd2;
	localparam logic [2:0] SEL_SCALAR = 3'd3;
	localparam logic [2:0] SEL_ZERO   = 3'd4;

	typedef struct packed {
		logic [1:0]        slide_mode;
		logic [CNT_W-1:0]  slide_offset;
		logic [ELEM_W-1:0] scalar_value;
		logic [CNT_W-1:0]  vector_length;
		logic              masked;
		logic              element_width;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        sel;
		logic              last;
		logic [ELEM_W-1:0] src;
		logic [ELEM_W-1:0] old;
	} s1_t;

	// element mask for the current width
	function automatic logic [ELEM_W-1:0] width_mask(input logic wide);
		logic [ELEM_W-1:0] m;
		m = wide ? {ELEM_W{1'b1}} : {{(ELEM_W/2){1'b0}}, {(ELEM_W/2){1'b1}}};
		return m;
	endfunction

	// length with zero taken as one and saturated at the buffer depth
	function automatic logic [LEN_W-1:0] clamp_len(input logic [CNT_W-1:0] vl);
		int v;
		v = int'(vl);
		if (v == 0) v = 1;
		if (v > MAX_LENGTH) v = MAX_LENGTH;
		return LEN_W'(v);
	endfunction

	// offset saturated at the length
	function automatic logic [LEN_W-1:0] clamp_off(input logic [CNT_W-1:0] offset,
		input logic [LEN_W-1:0] len);
		int o;
		o = int'(offset);
		if (o > int'(len)) o = int'(len);
		return LEN_W'(o);
	endfunction

endpackage

// ===== design/vse_if.sv =====
// ----------------------------------------------------------------------------
// vse interfaces
// element input, result output and register write channels
// ----------------------------------------------------------------------------
interface vse_in_if;
	logic                       valid;
	logic                       ready;
	logic [vse_pkg::ELEM_W-1:0] source_element;
	logic [vse_pkg::ELEM_W-1:0] old_dest_element;
	logic                       mask_active;

	modport source (output valid, source_element, old_dest_element, mask_active,
		input ready);
	modport sink (input valid, source_element, old_dest_element, mask_active,
		output ready);
endinterface

interface vse_out_if;
	logic                       valid;
	logic                       ready;
	logic [vse_pkg::ELEM_W-1:0] result_element;
	logic                       last;

	modport source (output valid, result_element, last, input ready);
	modport sink (input valid, result_element, last, output ready);
endinterface

interface vse_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [vse_pkg::IDX_W-1:0]  index;
	logic [vse_pkg::ELEM_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/vse_cfg.sv =====
// ----------------------------------------------------------------------------
// vse_cfg
// configuration registers and restart pulse
// ----------------------------------------------------------------------------
module vse_cfg (
	input  logic            clk,
	input  logic            arst_n,
	vse_cfg_if.sink         cfg,
	output vse_pkg::cfg_t   cfg_q,
	output logic            restart
);

	logic wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slide_mode    <= vse_pkg::MODE_SLIDEUP;
			cfg_q.slide_offset  <= '0;
			cfg_q.scalar_value  <= '0;
			cfg_q.vector_length <= vse_pkg::CNT_W'(1);
			cfg_q.masked        <= 1'b0;
			cfg_q.element_width <= 1'b1;
		end else if (wr) begin
			case (cfg.index)
				vse_pkg::REG_MODE:   cfg_q.slide_mode    <= cfg.data[1:0];
				vse_pkg::REG_OFFSET: cfg_q.slide_offset  <= cfg.data[vse_pkg::CNT_W-1:0];
				vse_pkg::REG_SCALAR: cfg_q.scalar_value  <= cfg.data;
				vse_pkg::REG_LENGTH: cfg_q.vector_length <= cfg.data[vse_pkg::CNT_W-1:0];
				vse_pkg::REG_MASKED: cfg_q.masked        <= cfg.data[0];
				vse_pkg::REG_EWIDTH: cfg_q.element_width <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		restart = 1'b0;
		if (wr) begin
			case (cfg.index)
				vse_pkg::REG_MODE, vse_pkg::REG_OFFSET, vse_pkg::REG_SCALAR,
				vse_pkg::REG_LENGTH, vse_pkg::REG_MASKED,
				vse_pkg::REG_EWIDTH: restart = 1'b1;
				default:             restart = 1'b0;
			endcase
		end
	end

endmodule

// ===== design/vse_buf.sv =====
// ----------------------------------------------------------------------------
// vse_buf
// source element buffer, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vse_buf (
	input  logic                        clk,
	input  logic                        we,
	input  logic [vse_pkg::POS_W-1:0]   waddr,
	input  logic [vse_pkg::ELEM_W-1:0]  wdata,
	input  logic                        re,
	input  logic [vse_pkg::POS_W-1:0]   raddr,
	output logic [vse_pkg::ELEM_W-1:0]  rdata
);

	logic [vse_pkg::ELEM_W-1:0] mem [vse_pkg::MAX_LENGTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/vse_ctrl.sv =====
// ----------------------------------------------------------------------------
// vse_ctrl
// element position, result source decode and first pipeline stage
// ----------------------------------------------------------------------------
module vse_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	vse_in_if.sink                      in_ch,
	input  vse_pkg::cfg_t               cfg_q,
	input  logic                        restart,
	input  logic                        load_s2,
	output logic                        valid_s1,
	output vse_pkg::s1_t                s1,
	output logic                        buf_we,
	output logic [vse_pkg::POS_W-1:0]   buf_waddr,
	output logic [vse_pkg::ELEM_W-1:0]  buf_wdata,
	output logic [vse_pkg::POS_W-1:0]   buf_raddr
);

	logic [vse_pkg::POS_W-1:0]  pos_q;
	logic [vse_pkg::LEN_W-1:0]  len;
	logic [vse_pkg::LEN_W-1:0]  off;
	logic [vse_pkg::LEN_W-1:0]  jx;
	logic [vse_pkg::LEN_W-1:0]  j_inc;
	logic [vse_pkg::ELEM_W-1:0] wmask;
	logic                       advance;
	logic                       accept;
	logic                       last;
	logic [2:0]                 sel;

	assign advance     = ~valid_s1 | load_s2;
	assign in_ch.ready = advance;
	assign accept      = in_ch.valid & advance;

	assign wmask = vse_pkg::width_mask(cfg_q.element_width);
	assign len   = vse_pkg::clamp_len(cfg_q.vector_length);
	assign off   = vse_pkg::clamp_off(cfg_q.slide_offset, len);
	assign jx    = vse_pkg::LEN_W'(pos_q);
	assign j_inc = jx + vse_pkg::LEN_W'(1);
	assign last  = (j_inc >= len);

	assign buf_we    = accept;
	assign buf_waddr = pos_q;
	assign buf_wdata = in_ch.source_element & wmask;
	assign buf_raddr = vse_pkg::POS_W'(jx - off);

	always_comb begin
		sel = vse_pkg::SEL_OLD;
		if (cfg_q.slide_mode == vse_pkg::MODE_SLIDEUP ||
			cfg_q.slide_mode == vse_pkg::MODE_SLIDE1UP) begin
			if (cfg_q.slide_mode == vse_pkg::MODE_SLIDE1UP && pos_q == '0) begin
				sel = vse_pkg::SEL_SCALAR;
			end else if (jx >= off) begin
				// zero offset reads the element arriving now
				sel = (off == '0) ? vse_pkg::SEL_SRC : vse_pkg::SEL_BUF;
			end else begin
				sel = vse_pkg::SEL_OLD;
			end
		end else begin
			if (cfg_q.slide_mode == vse_pkg::MODE_SLIDE1DOWN && j_inc == len) begin
				sel = vse_pkg::SEL_SCALAR;
			end else if (jx >= len - off) begin
				sel = vse_pkg::SEL_ZERO;
			end else begin
				sel = vse_pkg::SEL_SRC;
			end
		end
		if (cfg_q.masked && !in_ch.mask_active) begin
			sel = vse_pkg::SEL_OLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (restart) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= last ? '0 : vse_pkg::POS_W'(j_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1.sel  <= sel;
			s1.last <= last;
			s1.src  <= in_ch.source_element;
			s1.old  <= in_ch.old_dest_element;
		end
	end

endmodule

// ===== design/vse_out.sv =====
// ----------------------------------------------------------------------------
// vse_out
// result select and output register
// ----------------------------------------------------------------------------
module vse_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  vse_pkg::s1_t                s1,
	input  logic [vse_pkg::ELEM_W-1:0]  buf_rdata,
	input  vse_pkg::cfg_t               cfg_q,
	output logic                        load_s2,
	vse_out_if.source                   out_ch
);

	logic                       valid_q;
	logic [vse_pkg::ELEM_W-1:0] result_q;
	logic                       last_q;
	logic [vse_pkg::ELEM_W-1:0] res;

	assign load_s2 = ~valid_q | out_ch.ready;

	always_comb begin
		case (s1.sel)
			vse_pkg::SEL_OLD:    res = s1.old;
			vse_pkg::SEL_SRC:    res = s1.src;
			vse_pkg::SEL_BUF:    res = buf_rdata;
			vse_pkg::SEL_SCALAR: res = cfg_q.scalar_value;
			vse_pkg::SEL_ZERO:   res = '0;
			default:             res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_s2) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			result_q <= res & vse_pkg::width_mask(cfg_q.element_width);
			last_q   <= s1.last;
		end
	end

	assign out_ch.valid          = valid_q;
	assign out_ch.result_element = result_q;
	assign out_ch.last           = last_q;

endmodule

// ===== design/vector_slide_element_unit.sv =====
// ----------------------------------------------------------------------------
// vector_slide_element_unit
// slide up and down of vector elements, one element per transaction
// ----------------------------------------------------------------------------
// path: an element is registered into stage one, its result then into the
// output register, and both stages hold while the result channel stalls
// throughput: one element per cycle if out_ch does not stall, one buffer write
// at the current position and a registered read at position - offset at once
// reset: control state cleared, registers to their defaults; buffer not reset
// ----------------------------------------------------------------------------
module vector_slide_element_unit (
	input  logic       clk,
	input  logic       arst_n,
	vse_in_if.sink     in_ch,
	vse_out_if.source  out_ch,
	vse_cfg_if.sink    cfg
);

	vse_pkg::cfg_t              cfg_q;
	logic                       restart;
	logic                       load_s2;
	logic                       valid_s1;
	vse_pkg::s1_t               s1;
	logic                       buf_we;
	logic [vse_pkg::POS_W-1:0]  buf_waddr;
	logic [vse_pkg::ELEM_W-1:0] buf_wdata;
	logic [vse_pkg::POS_W-1:0]  buf_raddr;
	logic [vse_pkg::ELEM_W-1:0] buf_rdata;

	vse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_q   (cfg_q),
		.restart (restart)
	);

	vse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_q     (cfg_q),
		.restart   (restart),
		.load_s2   (load_s2),
		.valid_s1  (valid_s1),
		.s1        (s1),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_wdata (buf_wdata),
		.buf_raddr (buf_raddr)
	);

	vse_buf u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_we),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	vse_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.s1        (s1),
		.buf_rdata (buf_rdata),
		.cfg_q     (cfg_q),
		.load_s2   (load_s2),
		.out_ch    (out_ch)
	);

endmodule

// ===== sim/vse_checker.sv =====
// ----------------------------------------------------------------------------
// vse_checker
// watches the register, element and result channels of the slide unit, keeps
// its own copy of the registers and element store, works out each result
// element and compares it field by field with what the unit returns
// ----------------------------------------------------------------------------
module vse_checker (
	input  logic clk,
	input  logic arst_n,
	vse_in_if    in_ch,
	vse_out_if   out_ch,
	vse_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);

	localparam int EXP_DEPTH = 8;

	typedef struct packed {
		logic [vse_pkg::ELEM_W-1:0] result_element;
		logic                       last;
	} slide_result_t;

	vse_pkg::cfg_t              regs;
	logic [vse_pkg::ELEM_W-1:0] element_store [vse_pkg::MAX_LENGTH];
	int                         elem_pos;
	slide_result_t              expected_results [EXP_DEPTH];
	int                         exp_head = 0;
	int                         exp_count = 0;
	slide_result_t              want;
	int                         fails = 0;
	int                         pending = 0;

	assign mismatches  = fails;
	assign outstanding = pending;

	function automatic void note_mismatch(input string field,
		input logic [vse_pkg::ELEM_W-1:0] exp_v, input logic [vse_pkg::ELEM_W-1:0] got_v);
		fails++;
		if (fails <= 10)
			$display("mismatch at %0t: %s expected %h got %h", $time, field, exp_v, got_v);
	endfunction

	function automatic void write_register(input logic [vse_pkg::IDX_W-1:0] idx,
		input logic [vse_pkg::ELEM_W-1:0] data);
		logic hit;
		hit = 1'b1;
		case (idx)
			vse_pkg::REG_MODE:   regs.slide_mode    = data[1:0];
			vse_pkg::REG_OFFSET: regs.slide_offset  = data[vse_pkg::CNT_W-1:0];
			vse_pkg::REG_SCALAR: regs.scalar_value  = data;
			vse_pkg::REG_LENGTH: regs.vector_length = data[vse_pkg::CNT_W-1:0];
			vse_pkg::REG_MASKED: regs.masked        = data[0];
			vse_pkg::REG_EWIDTH: regs.element_width = data[0];
			default:             hit = 1'b0;
		endcase
		if (hit)
			elem_pos = 0;
	endfunction

	function automatic slide_result_t slide_element(input logic [vse_pkg::ELEM_W-1:0] src_in,
		input logic [vse_pkg::ELEM_W-1:0] old_in, input logic lane_on);
		logic [vse_pkg::ELEM_W-1:0] wmask;
		logic [vse_pkg::ELEM_W-1:0] src;
		logic [vse_pkg::ELEM_W-1:0] old;
		logic [vse_pkg::ELEM_W-1:0] scalar;
		int                         len;
		int                         off;
		int                         j;
		slide_result_t              r;
		wmask  = regs.element_width ? {vse_pkg::ELEM_W{1'b1}} : {32'h0, 32'hffff_ffff};
		src    = src_in & wmask;
		old    = old_in & wmask;
		scalar = regs.scalar_value & wmask;
		len    = int'(regs.vector_length);
		if (len == 0)
			len = 1;
		if (len > vse_pkg::MAX_LENGTH)
			len = vse_pkg::MAX_LENGTH;
		off = int'(regs.slide_offset);
		if (off > len)
			off = len;
		j = elem_pos;
		element_store[j] = src;
		case (regs.slide_mode)
			vse_pkg::MODE_SLIDEUP, vse_pkg::MODE_SLIDE1UP: begin
				if (regs.slide_mode == vse_pkg::MODE_SLIDE1UP && j == 0)
					r.result_element = scalar;
				else if (j >= off)
					r.result_element = element_store[j - off];
				else
					r.result_element = old;
			end
			default: begin
				if (regs.slide_mode == vse_pkg::MODE_SLIDE1DOWN && j + 1 == len)
					r.result_element = scalar;
				else if (j >= len - off)
					r.result_element = '0;
				else
					r.result_element = src;
			end
		endcase
		// masked-off lane keeps the old element
		if (regs.masked && !lane_on)
			r.result_element = old;
		r.result_element = r.result_element & wmask;
		r.last           = (j + 1 >= len);
		elem_pos         = r.last ? 0 : j + 1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.slide_mode    = vse_pkg::MODE_SLIDEUP;
			regs.slide_offset  = '0;
			regs.scalar_value  = '0;
			regs.vector_length = vse_pkg::CNT_W'(1);
			regs.masked        = 1'b0;
			regs.element_width = 1'b1;
			elem_pos           = 0;
			exp_head           = 0;
			exp_count          = 0;
			pending            = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (exp_count == 0) begin
					note_mismatch("result with nothing expected", '0, out_ch.result_element);
				end else begin
					want      = expected_results[exp_head];
					exp_head  = (exp_head + 1) % EXP_DEPTH;
					exp_count = exp_count - 1;
					if (out_ch.result_element !== want.result_element)
						note_mismatch("result_element", want.result_element,
							out_ch.result_element);
					if (out_ch.last !== want.last)
						note_mismatch("last", vse_pkg::ELEM_W'(want.last),
							vse_pkg::ELEM_W'(out_ch.last));
				end
			end
			if (cfg.valid && cfg.ready)
				write_register(cfg.index, cfg.data);
			if (in_ch.valid && in_ch.ready) begin
				expected_results[(exp_head + exp_count) % EXP_DEPTH] =
					slide_element(in_ch.source_element, in_ch.old_dest_element,
					in_ch.mask_active);
				exp_count = exp_count + 1;
			end
			pending = exp_count;
		end
	end

endmodule

// ===== sim/vector_slide_element_unit_tb.sv =====
// ----------------------------------------------------------------------------
// vector_slide_element_unit_tb
// drives the slide unit through directed vectors for each slide mode, mask
// and width corner, then through randomly configured vectors with random
// stalls on both channels; the checker beside the unit compares every result
// ----------------------------------------------------------------------------
module vector_slide_element_unit_tb;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 160;
	localparam int TOTAL_ITEMS  = 1650;
	localparam int CALM_ITEMS   = 200;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   src_idle_odds  = 0;
	int   sink_idle_odds = 4;
	bit   hold_req       = 1'b0;
	int   sent           = 0;
	int   quiet_cycles   = 0;
	int   odds_table [4] = '{0, 3, 6, 12};

	vse_in_if  in_ch ();
	vse_out_if out_ch ();
	vse_cfg_if cfg ();

	vector_slide_element_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	vse_checker slide_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("vector_slide_element_unit test failed");
			$finish;
		end
	end

	// result side
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_idle_odds != 0 && $urandom_range(1, sink_idle_odds) == 1) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [vse_pkg::ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_element(input logic [vse_pkg::ELEM_W-1:0] src,
		input logic [vse_pkg::ELEM_W-1:0] old, input logic lane_on);
		if (src_idle_odds != 0 && $urandom_range(1, src_idle_odds) == 1) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.source_element   <= src;
		in_ch.old_dest_element <= old;
		in_ch.mask_active      <= lane_on;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [vse_pkg::IDX_W-1:0] idx,
		input logic [vse_pkg::ELEM_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] mode, input logic [vse_pkg::CNT_W-1:0] offset,
		input logic [vse_pkg::ELEM_W-1:0] scalar, input logic [vse_pkg::CNT_W-1:0] len,
		input logic msk, input logic wide);
		logic [vse_pkg::ELEM_W-1:0] noise;
		settle();
		noise = {$urandom, $urandom};
		write_reg(vse_pkg::REG_MODE, {noise[vse_pkg::ELEM_W-1:2], mode});
		write_reg(vse_pkg::REG_OFFSET, {noise[vse_pkg::ELEM_W-1:vse_pkg::CNT_W], offset});
		write_reg(vse_pkg::REG_SCALAR, scalar);
		write_reg(vse_pkg::REG_LENGTH, {noise[vse_pkg::ELEM_W-1:vse_pkg::CNT_W], len});
		write_reg(vse_pkg::REG_MASKED, {noise[vse_pkg::ELEM_W-1:1], msk});
		write_reg(vse_pkg::REG_EWIDTH, {noise[vse_pkg::ELEM_W-1:1], wide});
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic [1:0]                mode;
		logic [vse_pkg::CNT_W-1:0] len;
		logic [vse_pkg::CNT_W-1:0] offset;
		int                        eff_len;
		int                        count;
		bit                        held;
		bit                        paused;
		held   = 1'b0;
		paused = 1'b0;
		in_ch.valid            <= 1'b0;
		in_ch.source_element   <= '0;
		in_ch.old_dest_element <= '0;
		in_ch.mask_active      <= 1'b0;
		cfg.valid              <= 1'b0;
		cfg.index              <= vse_pkg::REG_MODE;
		cfg.data               <= '0;
		arst_n                 <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults after reset
		send_element('1, '0, 1'b0);

		configure(vse_pkg::MODE_SLIDEUP, 7'd2, '0, 7'd4, 1'b0, 1'b1);
		send_element(64'h0123_4567_89ab_cdef, '0, 1'b1);
		send_element('1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_element('0, '1, 1'b1);
		send_element(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 1'b0);

		// narrow elements with scalar insert
		configure(vse_pkg::MODE_SLIDE1UP, 7'd1, '1, 7'd3, 1'b0, 1'b0);
		send_element('1, '1, 1'b1);
		send_element(64'hdead_beef_0000_0001, '1, 1'b0);
		send_element('0, 64'h1234_5678_9abc_def0, 1'b1);

		// masked-off lane where a zero would go
		configure(vse_pkg::MODE_SLIDEDOWN, 7'd1, '0, 7'd4, 1'b1, 1'b1);
		send_element(64'h0f0f_0f0f_0f0f_0f0f, '1, 1'b0);
		send_element('1, 64'h1111_2222_3333_4444, 1'b1);
		send_element(64'hfedc_ba98_7654_3210, '0, 1'b1);
		send_element('1, 64'h7777_8888_9999_aaaa, 1'b0);

		// masked-off lane where the scalar would go
		configure(vse_pkg::MODE_SLIDE1DOWN, 7'd0, 64'hffff_0000_ffff_0000, 7'd3, 1'b1, 1'b1);
		send_element('1, '0, 1'b1);
		send_element('0, '1, 1'b1);
		send_element(64'h0000_0001_0000_0001, 64'h0bad_cafe_0bad_cafe, 1'b0);

		// zero length, offset beyond length
		configure(vse_pkg::MODE_SLIDEUP, 7'd100, '1, 7'd0, 1'b0, 1'b1);
		send_element('1, 64'h0101_0101_0101_0101, 1'b1);
		send_element(64'h0202_0202_0202_0202, '0, 1'b0);

		// length above the buffer depth
		configure(vse_pkg::MODE_SLIDEDOWN, 7'd127, '0, 7'd127, 1'b0, 1'b0);
		send_element('1, '1, 1'b1);
		send_element(64'h1357_9bdf_2468_ace0, '0, 1'b0);
		send_element('0, '1, 1'b1);

		while (sent < TOTAL_ITEMS) begin
			mode = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 19))
				0:       len = '0;
				1:       len = vse_pkg::CNT_W'($urandom_range(vse_pkg::MAX_LENGTH + 1, 127));
				2:       len = vse_pkg::CNT_W'(vse_pkg::MAX_LENGTH);
				3, 4:    len = vse_pkg::CNT_W'($urandom_range(9, vse_pkg::MAX_LENGTH));
				default: len = vse_pkg::CNT_W'($urandom_range(1, 8));
			endcase
			eff_len = (len == 0) ? 1 : ((int'(len) > vse_pkg::MAX_LENGTH) ?
				vse_pkg::MAX_LENGTH : int'(len));
			case ($urandom_range(0, 9))
				0:       offset = '0;
				1:       offset = vse_pkg::CNT_W'(eff_len);
				2:       offset = vse_pkg::CNT_W'($urandom_range(vse_pkg::MAX_LENGTH + 1, 127));
				default: offset = vse_pkg::CNT_W'($urandom_range(0, eff_len));
			endcase
			configure(mode, offset, rand_elem(), len, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			if (sent >= TOTAL_ITEMS - CALM_ITEMS) begin
				src_idle_odds  = 0;
				sink_idle_odds = 0;
			end else begin
				src_idle_odds  = odds_table[$urandom_range(0, 3)];
				sink_idle_odds = odds_table[$urandom_range(0, 3)];
			end
			count = eff_len * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				count += $urandom_range(0, eff_len - 1);
			// long receiver stall while elements keep coming
			if (!held && sent > 400) begin
				held          = 1'b1;
				src_idle_odds = 0;
				count        += 40;
				hold_req      = 1'b1;
			end
			for (int i = 0; i < count; i++) begin
				if (!paused && sent >= 900 && i > 0) begin
					paused = 1'b1;
					settle();
				end
				send_element(rand_elem(), rand_elem(), 1'($urandom_range(0, 1)));
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("vector_slide_element_unit test passed");
		else
			$display("vector_slide_element_unit test failed");
		$finish;
	end

endmodule

// ===== vector_slide_element_unit.f =====
design/vse_pkg.sv
design/vse_if.sv
design/vse_cfg.sv
design/vse_buf.sv
design/vse_ctrl.sv
design/vse_out.sv
design/vector_slide_element_unit.sv
sim/vse_checker.sv
sim/vector_slide_element_unit_tb.sv
